/* rtl/ypcu_pkg.sv */
// Package: types, constants and functions for the yaw/pitch camera update unit.
package ypcu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int STEP_W        = 5;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [33:0] QUARTER  = 34'sd1073741824;

  localparam logic [2:0] CFG_TURN_GAIN   = 3'd0;
  localparam logic [2:0] CFG_MOVE_STEP   = 3'd1;
  localparam logic [2:0] CFG_BOUND_HIGH  = 3'd2;
  localparam logic [2:0] CFG_BOUND_LOW_X = 3'd3;
  localparam logic [2:0] CFG_BOUND_LOW_YZ = 3'd4;
  localparam logic [2:0] CFG_CURSOR_CTR  = 3'd5;

  typedef struct packed {
    logic signed [11:0] cursor_x;
    logic signed [11:0] cursor_y;
    logic               key_forward;
    logic               key_back;
    logic               key_right;
    logic               key_left;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         vector_id;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOVE, ST_EMIT, ST_ANGLE, ST_CORDIC_YAW, ST_CORDIC_PITCH,
    ST_MATRIX, ST_ROTATE, ST_DONE
  } ypcu_state_t;

  typedef struct packed {
    logic       load;      // latch request, start eye move
    logic       move;      // one eye axis step
    logic       emit;      // present result
    logic       angle;     // update yaw and pitch
    logic       cordic;    // one CORDIC iteration
    logic       cordic_init;
    logic       cordic_sel; // 0 yaw, 1 pitch
    logic       matrix;    // one matrix product step
    logic       rotate;    // one rotation step
    logic [4:0] idx;
  } ypcu_cmd_t;

  function automatic logic signed [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'sd536870912;  5'd1: r = 32'sd316933406;
        5'd2: r = 32'sd167458907;  5'd3: r = 32'sd85004756;
        5'd4: r = 32'sd42667331;   5'd5: r = 32'sd21354465;
        5'd6: r = 32'sd10679838;   5'd7: r = 32'sd5340245;
        5'd8: r = 32'sd2670163;    5'd9: r = 32'sd1335087;
        5'd10: r = 32'sd667544;    5'd11: r = 32'sd333772;
        5'd12: r = 32'sd166886;    5'd13: r = 32'sd83443;
        5'd14: r = 32'sd41721;     5'd15: r = 32'sd20860;
        5'd16: r = 32'sd10430;     5'd17: r = 32'sd5215;
        5'd18: r = 32'sd2607;      5'd19: r = 32'sd1303;
        5'd20: r = 32'sd651;       5'd21: r = 32'sd325;
        5'd22: r = 32'sd162;       5'd23: r = 32'sd81;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

  // Start vectors in half units: side, forward, lb, rb, lt, rt.
  function automatic logic signed [2:0] start_half(input logic [2:0] k,
                                                    input logic [1:0] j);
    logic signed [2:0] r;
    begin
      r = 3'sd0;
      unique case (k)
        3'd0: r = (j == 2'd0) ? 3'sd2 : 3'sd0;
        3'd1: r = (j == 2'd2) ? 3'sd3 : 3'sd0;
        3'd2: r = (j == 2'd2) ? 3'sd3 : -3'sd2;
        3'd3: r = (j == 2'd0) ? 3'sd2 : ((j == 2'd1) ? -3'sd2 : 3'sd3);
        3'd4: r = (j == 2'd0) ? -3'sd2 : ((j == 2'd1) ? 3'sd2 : 3'sd3);
        3'd5: r = (j == 2'd2) ? 3'sd3 : 3'sd2;
        default: r = 3'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/ypcu_ctrl.sv */
// Controller: sequences eye move, result emission, angle update, CORDIC, matrix products and rotation.
module ypcu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_busy,
  input  logic                out_taken,
  output ypcu_pkg::ypcu_cmd_t cmd
);
  import ypcu_pkg::*;

  ypcu_state_t state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOVE;
          idx_nxt   = '0;
        end
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        // advance the angles early so the CORDIC load sees the new yaw
        cmd.angle = (idx_r == 5'd2);
        if (idx_r == 5'd2) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end else idx_nxt = idx_r + 5'd1;
      end
      ST_EMIT: begin
        if (!out_busy || out_taken) begin
          cmd.emit = 1'b1;
          if (idx_r == 5'd4) begin
            state_nxt = ST_ANGLE;
            idx_nxt   = '0;
          end else idx_nxt = idx_r + 5'd1;
        end
      end
      ST_ANGLE: begin
        cmd.cordic_init = 1'b1;
        state_nxt = ST_CORDIC_YAW;
      end
      ST_CORDIC_YAW: begin
        cmd.cordic = 1'b1;
        if (idx_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_CORDIC_PITCH;
          idx_nxt   = '0;
          cmd.cordic_init = 1'b0;
        end else idx_nxt = idx_r + 5'd1;
      end
      ST_CORDIC_PITCH: begin
        cmd.cordic     = 1'b1;
        cmd.cordic_sel = 1'b1;
        cmd.cordic_init = (idx_r == 5'd0);
        if (idx_r == 5'(CORDIC_STEPS)) begin
          state_nxt = ST_MATRIX;
          idx_nxt   = '0;
        end else idx_nxt = idx_r + 5'd1;
      end
      ST_MATRIX: begin
        cmd.matrix = 1'b1;
        if (idx_r == 5'd4) begin
          state_nxt = ST_ROTATE;
          idx_nxt   = '0;
        end else idx_nxt = idx_r + 5'd1;
      end
      ST_ROTATE: begin
        cmd.rotate = 1'b1;
        if (idx_r == 5'd17) state_nxt = ST_DONE;
        else idx_nxt = idx_r + 5'd1;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

/* rtl/ypcu_datapath.sv */
// Datapath: eye, angles, CORDIC, rotation matrix and frame vectors.
module ypcu_datapath #(
  parameter int FRAC_BITS = ypcu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ypcu_pkg::ypcu_cmd_t cmd,
  input  ypcu_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output ypcu_pkg::out_item_t res
);
  import ypcu_pkg::*;

  logic [19:0]        turn_gain_r, move_step_r;
  logic signed [23:0] bound_high_r, bound_low_x_r, bound_low_yz_r;
  logic [10:0]        cursor_center_r;
  in_item_t           req_r;
  logic signed [23:0] eye_r [3];
  logic signed [23:0] vec_r [6][3];
  logic [31:0]        yaw_r, pitch_r;

  // Start value of a vector coordinate, saturated to 24 bits.
  function automatic logic signed [23:0] start_val(input logic [2:0] k, input logic [1:0] j);
    logic signed [47:0] v;
    begin
      v = 48'(start_half(k, j)) <<< (FRAC_BITS - 1);
      if (v > 48'sd8388607) return 24'sd8388607;
      else if (v < -48'sd8388608) return -24'sd8388608;
      else return v[23:0];
    end
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_gain_r     <= 20'd123042;
      move_step_r     <= 20'd8520;
      bound_high_r    <= 24'sd2490368;
      bound_low_x_r   <= -24'sd5242880;
      bound_low_yz_r  <= -24'sd2490368;
      cursor_center_r <= 11'd235;
    end else if (cfg_valid) begin
      priority case (cfg_index)
        CFG_TURN_GAIN:    turn_gain_r     <= cfg_data[19:0];
        CFG_MOVE_STEP:    move_step_r     <= cfg_data[19:0];
        CFG_BOUND_HIGH:   bound_high_r    <= cfg_data;
        CFG_BOUND_LOW_X:  bound_low_x_r   <= cfg_data;
        CFG_BOUND_LOW_YZ: bound_low_yz_r  <= cfg_data;
        CFG_CURSOR_CTR:   cursor_center_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) if (cmd.load) req_r <= in_data;

  // Eye move, one axis per cycle
  logic [1:0]         ax;
  logic signed [45:0] fprod, sprod, rnd;
  logic signed [26:0] fstep, sstep, enew, ehi;
  logic signed [23:0] lo, eclamp;
  assign ax = cmd.idx[1:0];
  always_comb begin
    rnd   = 46'sd1 <<< (FRAC_BITS - 1);
    fprod = vec_r[1][ax] * $signed({1'b0, move_step_r});
    sprod = vec_r[0][ax] * $signed({1'b0, move_step_r});
    fstep = 27'((fprod + rnd) >>> FRAC_BITS);
    sstep = 27'((sprod + rnd) >>> FRAC_BITS);
    enew  = 27'(eye_r[ax]);
    if (req_r.key_forward) enew = enew + fstep;
    if (req_r.key_back)    enew = enew - fstep;
    if (req_r.key_right)   enew = enew + sstep;
    if (req_r.key_left)    enew = enew - sstep;
    lo = (ax == 2'd0) ? bound_low_x_r : bound_low_yz_r;
    // upper bound first, then the lower bound wins
    ehi    = (enew >= 27'(bound_high_r)) ? 27'(bound_high_r) : enew;
    eclamp = (ehi <= 27'(lo)) ? lo : ehi[23:0];
  end

  // Angles
  logic signed [12:0] dx, dy;
  logic signed [33:0] dxg, dyg, pnew;
  always_comb begin
    dx   = 13'(req_r.cursor_x) - $signed({2'b0, cursor_center_r});
    dy   = 13'(req_r.cursor_y) - $signed({2'b0, cursor_center_r});
    dxg  = 34'(dx * $signed({1'b0, turn_gain_r}));
    dyg  = 34'(dy * $signed({1'b0, turn_gain_r}));
    pnew = 34'($signed(pitch_r)) + dyg;
    if (pnew >= QUARTER) pnew = QUARTER;
    if (pnew <= -QUARTER) pnew = -QUARTER;
  end

  // CORDIC
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic signed [33:0] sa_r, ca_r, sb_r, cb_r;
  logic [31:0]        ang;
  logic               qflip;
  logic [4:0]         ci;
  assign ang   = cmd.cordic_sel ? pitch_r : yaw_r;
  assign qflip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
  assign ci    = cmd.idx;

  always_ff @(posedge clk) begin
    if (cmd.cordic_init && !(cmd.cordic && cmd.cordic_sel)) begin
      cx_r <= CORDIC_K; cy_r <= '0; flip_r <= qflip;
      cz_r <= 34'($signed(ang ^ {qflip, 31'b0}));
    end else if (cmd.cordic) begin
      if (cmd.cordic_sel && ci == 5'd0) begin
        sa_r <= flip_r ? -cy_r : cy_r;
        ca_r <= flip_r ? -cx_r : cx_r;
        cx_r <= CORDIC_K; cy_r <= '0; flip_r <= qflip;
        cz_r <= 34'($signed(ang ^ {qflip, 31'b0}));
      end else begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - (cy_r >>> (cmd.cordic_sel ? ci - 5'd1 : ci));
          cy_r <= cy_r + (cx_r >>> (cmd.cordic_sel ? ci - 5'd1 : ci));
          cz_r <= cz_r - 34'(atan_entry(cmd.cordic_sel ? ci - 5'd1 : ci));
        end else begin
          cx_r <= cx_r + (cy_r >>> (cmd.cordic_sel ? ci - 5'd1 : ci));
          cy_r <= cy_r - (cx_r >>> (cmd.cordic_sel ? ci - 5'd1 : ci));
          cz_r <= cz_r + 34'(atan_entry(cmd.cordic_sel ? ci - 5'd1 : ci));
        end
      end
    end
    if (cmd.matrix && cmd.idx == 5'd0) begin
      sb_r <= flip_r ? -cy_r : cy_r;
      cb_r <= flip_r ? -cx_r : cx_r;
    end
  end

  // Matrix products: latch the pitch result, then sa*sb, sa*cb, ca*sb, ca*cb
  logic signed [33:0] m01_r, m02_r, m21_r, m22_r, pa, pb;
  logic signed [67:0] mp;
  always_comb begin
    priority case (cmd.idx[1:0])
      2'd1: begin pa = sa_r; pb = sb_r; end
      2'd2: begin pa = sa_r; pb = cb_r; end
      2'd3: begin pa = ca_r; pb = sb_r; end
      default: begin pa = ca_r; pb = cb_r; end
    endcase
    mp = 68'((68'(pa) * 68'(pb) + 68'sd536870912) >>> 30);
  end
  always_ff @(posedge clk) begin
    if (cmd.matrix && cmd.idx != 5'd0) begin
      unique case (cmd.idx[1:0])
        2'd1: m01_r <= -mp[33:0];
        2'd2: m02_r <= -mp[33:0];
        2'd3: m21_r <= mp[33:0];
        default: m22_r <= mp[33:0];
      endcase
    end
  end

  // Rotation: one vector coordinate per cycle
  logic [2:0]         rk;
  logic [1:0]         ri;
  logic [7:0]         rmul;
  logic [4:0]         rk3;
  logic signed [33:0] r0, r1, r2;
  logic signed [59:0] acc;
  logic signed [59:0] racc;
  always_comb begin
    // vector = idx / 3 by reciprocal multiply, exact for idx up to 17
    rmul = 8'(cmd.idx) * 8'd11;
    rk   = rmul[7:5];
    rk3  = {2'b0, rk} + {1'b0, rk, 1'b0};
    ri   = 2'(cmd.idx - rk3);
    unique case (ri)
      2'd0: begin r0 = ca_r; r1 = m01_r; r2 = m02_r; end
      2'd1: begin r0 = '0; r1 = cb_r; r2 = -sb_r; end
      default: begin r0 = sa_r; r1 = m21_r; r2 = m22_r; end
    endcase
    acc = 60'(r0 * start_val(rk, 2'd0)) + 60'(r1 * start_val(rk, 2'd1))
        + 60'(r2 * start_val(rk, 2'd2));
    racc = (acc + 60'sd536870912) >>> 30;
  end

  // Emission register
  logic [2:0] ek;
  assign ek = 3'(cmd.idx) + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r <= '0; pitch_r <= '0;
      for (int j = 0; j < 3; j++) eye_r[j] <= '0;
      for (int k = 0; k < 6; k++)
        for (int j = 0; j < 3; j++)
          vec_r[k][j] <= (k < 2) ? 24'sd0 : start_val(3'(k), 2'(j));
    end else begin
      if (cmd.move) eye_r[ax] <= eclamp;
      if (cmd.angle) begin
        yaw_r   <= yaw_r - dxg[31:0];
        pitch_r <= pnew[31:0];
      end
      if (cmd.rotate)
        vec_r[rk][ri] <= (racc > 60'sd8388607) ? 24'sd8388607 :
                         (racc < -60'sd8388608) ? -24'sd8388608 : racc[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.vector_id <= cmd.idx[2:0];
      res.last      <= (cmd.idx == 5'd4);
      if (cmd.idx == 5'd0) begin
        res.coord_x <= eye_r[0]; res.coord_y <= eye_r[1]; res.coord_z <= eye_r[2];
      end else begin
        res.coord_x <= vec_r[ek][0]; res.coord_y <= vec_r[ek][1];
        res.coord_z <= vec_r[ek][2];
      end
    end
  end
endmodule

/* rtl/yaw_pitch_camera_update_unit.sv */
// Top level of the yaw/pitch camera update unit.
//   channel | direction | handshake       | payload
//   in_     | input     | valid / stall   | in_item_t
//   out_    | output    | valid / stall   | out_item_t
//   cfg_    | input     | valid / ready   | index, data
// From its acceptance to the next one a request passes through: the accepting
// cycle, 3 eye axis steps, 5 results (longer while the output stalls), the CORDIC
// load, the yaw and pitch CORDIC iterations, the matrix products, 18 rotation
// steps and the closing state. The first result follows the eye axis steps.
// Reset is synchronous and needs no clearing pass. A new request is taken only
// once the previous one ends.
module yaw_pitch_camera_update_unit #(
  parameter int FRAC_BITS = ypcu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ypcu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ypcu_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import ypcu_pkg::*;

  ypcu_cmd_t cmd;
  logic      out_valid_r;
  logic      taken;

  assign taken     = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (taken) out_valid_r <= 1'b0;
  end

  ypcu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .out_busy(out_valid_r), .out_taken(taken), .cmd
  );

  ypcu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_data,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .res(out_data)
  );

`ifndef ASSERT_OFF
  a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("request accepted twice");
  a_last_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.vector_id == 3'd4))
    else $error("last on wrong result");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || taken)) else $error("result overwritten");
`endif
endmodule

/* tb/tb_top.sv */
// Testbench for the yaw/pitch camera update unit: random frames checked against a predictor.
module tb_top;
  import ypcu_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 300;
  localparam int HOLD_CYC    = 400;

  // Predicts the five vectors of each frame and checks them in order.
  class camera_scoreboard;
    out_item_t    frame_q[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  frames;
    longint       turn_gain, move_step, cursor_ctr;
    longint       bound_high, bound_low_x, bound_low_yz;
    longint       eye[3];
    logic [31:0]  yaw, pitch;
    longint       vec[6][3];

    function new();
      turn_gain    = 123042;
      move_step    = 8520;
      bound_high   = 2490368;
      bound_low_x  = -5242880;
      bound_low_yz = -2490368;
      cursor_ctr   = 235;
      yaw          = '0;
      pitch        = '0;
      for (int i = 0; i < 3; i++) eye[i] = 0;
      for (int k = 0; k < 6; k++)
        for (int j = 0; j < 3; j++) vec[k][j] = (k < 2) ? 0 : start_coord(k, j);
    endfunction

    function longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint rnd30(longint p);
      return (p + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function longint start_coord(int k, int j);
      int half[6][3] = '{'{2, 0, 0}, '{0, 0, 3}, '{-2, -2, 3}, '{2, -2, 3},
                         '{-2, 2, 3}, '{2, 2, 3}};
      return sat24(longint'(half[k][j]) * (longint'(1) <<< 16) / 2);
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        CFG_TURN_GAIN:    turn_gain    = longint'(d[19:0]);
        CFG_MOVE_STEP:    move_step    = longint'(d[19:0]);
        CFG_BOUND_HIGH:   bound_high   = longint'(signed'(d));
        CFG_BOUND_LOW_X:  bound_low_x  = longint'(signed'(d));
        CFG_BOUND_LOW_YZ: bound_low_yz = longint'(signed'(d));
        CFG_CURSOR_CTR:   cursor_ctr   = longint'(d[10:0]);
        default: ;
      endcase
    endfunction

    function void sin_cos(logic [31:0] a, output longint s, output longint c);
      longint x, y, z, t;
      bit     flip;
      x = 652032874;
      y = 0;
      flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      if (flip) a[31] = ~a[31];
      z = longint'(signed'(a));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(atan_entry(i));
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(atan_entry(i));
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void rebuild();
      longint sa, ca, sb, cb;
      longint r[3][3];
      sin_cos(yaw, sa, ca);
      sin_cos(pitch, sb, cb);
      r[0][0] = ca; r[0][1] = -rnd30(sa * sb); r[0][2] = -rnd30(sa * cb);
      r[1][0] = 0;  r[1][1] = cb;              r[1][2] = -sb;
      r[2][0] = sa; r[2][1] = rnd30(ca * sb);  r[2][2] = rnd30(ca * cb);
      for (int k = 0; k < 6; k++)
        for (int i = 0; i < 3; i++)
          vec[k][i] = sat24(rnd30(r[i][0] * start_coord(k, 0) +
                                  r[i][1] * start_coord(k, 1) +
                                  r[i][2] * start_coord(k, 2)));
    endfunction

    function void note_request(in_item_t it);
      int        fsign, ssign;
      longint    e, lo, fwd, sid, dx, dy, p, ny;
      out_item_t o;
      fsign = int'(it.key_forward) - int'(it.key_back);
      ssign = int'(it.key_right) - int'(it.key_left);
      for (int i = 0; i < 3; i++) begin
        lo  = (i == 0) ? bound_low_x : bound_low_yz;
        fwd = (vec[1][i] * move_step + (longint'(1) <<< 15)) >>> 16;
        sid = (vec[0][i] * move_step + (longint'(1) <<< 15)) >>> 16;
        e   = eye[i] + fsign * fwd + ssign * sid;
        if (e >= bound_high) e = bound_high;
        if (e <= lo) e = lo;
        eye[i] = e;
      end
      for (int r = 0; r < 5; r++) begin
        o.vector_id = 3'(r);
        o.coord_x   = (r == 0) ? 24'(eye[0]) : 24'(vec[r + 1][0]);
        o.coord_y   = (r == 0) ? 24'(eye[1]) : 24'(vec[r + 1][1]);
        o.coord_z   = (r == 0) ? 24'(eye[2]) : 24'(vec[r + 1][2]);
        o.last      = (r == 4);
        frame_q.push_back(o);
      end
      dx = longint'(it.cursor_x) - cursor_ctr;
      dy = longint'(it.cursor_y) - cursor_ctr;
      ny = longint'(yaw) - dx * turn_gain;
      yaw = ny[31:0];
      p = longint'(signed'(pitch)) + dy * turn_gain;
      if (p >= 64'sd1073741824) p = 64'sd1073741824;
      if (p <= -64'sd1073741824) p = -64'sd1073741824;
      pitch = p[31:0];
      rebuild();
      frames++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result id=%0d", got.vector_id);
        return;
      end
      want = frame_q.pop_front();
      if (got.vector_id != want.vector_id || got.coord_x != want.coord_x ||
          got.coord_y != want.coord_y || got.coord_z != want.coord_z ||
          got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want id=%0d (%0d,%0d,%0d) last=%0b, got id=%0d (%0d,%0d,%0d) last=%0b",
                   want.vector_id, want.coord_x, want.coord_y, want.coord_z, want.last,
                   got.vector_id, got.coord_x, got.coord_y, got.coord_z, got.last);
      end
    endfunction

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_stall;
  in_item_t    in_data;
  logic        out_valid, out_stall;
  out_item_t   out_data;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  camera_scoreboard sb = new();
  int  burst_left;
  int  idle_cycles;
  bit  long_hold;
  int  ctr_now;

  yaw_pitch_camera_update_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitors: note requests, config writes and results as they are taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall: randomly chosen patterns, plus one long hold.
  initial begin
    int mode;
    out_stall <= 1'b0;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        for (int c = 0; c < 64; c++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= c[3];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Drain the block and let the vector rebuild finish before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(int gain, int step, int bh, int blx, int blyz, int ctr);
    write_reg(CFG_TURN_GAIN, 24'(gain));
    write_reg(CFG_MOVE_STEP, 24'(step));
    write_reg(CFG_BOUND_HIGH, 24'(bh));
    write_reg(CFG_BOUND_LOW_X, 24'(blx));
    write_reg(CFG_BOUND_LOW_YZ, 24'(blyz));
    write_reg(CFG_CURSOR_CTR, 24'(ctr));
    ctr_now = ctr;
  endtask

  function automatic in_item_t make_item(int cx, int cy, logic [3:0] keys);
    in_item_t it;
    it.cursor_x    = 12'(cx);
    it.cursor_y    = 12'(cy);
    it.key_forward = keys[3];
    it.key_back    = keys[2];
    it.key_right   = keys[1];
    it.key_left    = keys[0];
    return it;
  endfunction

  // Mostly small offsets from the centre so pitch keeps moving; some full range.
  function automatic in_item_t rand_item();
    int cx, cy;
    if ($urandom_range(0, 4) == 0) begin
      cx = $urandom_range(0, 4095) - 2048;
      cy = $urandom_range(0, 4095) - 2048;
    end else begin
      cx = ctr_now + $urandom_range(0, 80) - 40;
      cy = ctr_now + $urandom_range(0, 80) - 40;
      if (cx > 2047) cx = 2047;
      if (cy > 2047) cy = 2047;
    end
    return make_item(cx, cy, 4'($urandom_range(0, 15)));
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_item(rand_item());
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    long_hold  = 1'b0;
    burst_left = 0;
    ctr_now    = 235;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: centre, extremes, each single key, each key pair including opposite keys, all four.
    send_item(make_item(235, 235, 4'b1000));
    send_item(make_item(235, 235, 4'b1000));
    send_item(make_item(300, 200, 4'b0010));
    send_item(make_item(235, 235, 4'b1100));
    send_item(make_item(235, 235, 4'b0011));
    send_item(make_item(235, 235, 4'b1111));
    send_item(make_item(2047, 2047, 4'b0100));
    send_item(make_item(-2048, -2048, 4'b0001));
    send_item(make_item(-2048, 2047, 4'b1010));
    send_item(make_item(2047, -2048, 4'b0101));
    send_item(make_item(0, 0, 4'b1001));
    send_item(make_item(-1, -1, 4'b0110));
    for (int i = 0; i < 10; i++) send_item(make_item(235, 235, 4'b1010));
    wait_idle();

    // Zero gain, widest step and bounds, centre at zero; index beyond the list.
    set_all(0, 1048575, 8388607, -8388608, -8388608, 0);
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    long_hold = 1'b1;
    run_random(80);
    wait_idle();

    // Largest gain, no step, crossed bounds, centre at the top.
    set_all(1048575, 0, -100000, 200000, 0, 2047);
    run_random(40);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    run_random(40);
    wait_idle();

    // Moderate settings with heavy movement.
    set_all(400000, 300000, 3000000, -3000000, -1000000, 1000);
    run_random(80);
    wait_idle();

    // Random settings, crossed bounds allowed.
    set_all($urandom_range(0, 1048575), $urandom_range(0, 1048575),
            int'($urandom_range(0, 16777215)) - 8388608,
            int'($urandom_range(0, 16777215)) - 8388608,
            int'($urandom_range(0, 16777215)) - 8388608, $urandom_range(0, 2047));
    run_random(80);
    wait_idle();

    // Back to the reset values, tight bounds so the clamp is hit often.
    set_all(123042, 8520, 2490368, -5242880, -2490368, 235);
    run_random(60);
    wait_idle();
    write_reg(CFG_MOVE_STEP, 24'd0);
    set_all(123042, 200000, 100000, -100000, -100000, 235);
    run_random(60);

    wait_idle();
    $display("Covered %0d frames and %0d results over six register settings,",
             sb.frames, sb.checked);
    $display("including gain and step extremes, crossed bounds and long output stalls.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
